// ===== design/aciq_pkg.sv =====
package aciq_pkg;

	localparam int KEY_W         = 16;
	localparam int COUNT_W       = 8;
	localparam int FREE_W        = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int KEY_BITS_DEF  = 16;

	localparam logic [FREE_W-1:0] MAX_UNITS     = 8'd255;
	localparam logic [FREE_W-1:0] DEFAULT_UNITS = 8'd10;

	typedef enum logic [1:0] {
		OP_ARRIVE  = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CANCEL  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		EV_GRANTED       = 3'd0,
		EV_QUEUED        = 3'd1,
		EV_REJECTED      = 3'd2,
		EV_CANCEL_MISS   = 3'd3,
		EV_CANCEL_DONE   = 3'd4,
		EV_RELEASE_DONE  = 3'd5
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAIN
	} state_t;

	// broadcast to every queue cell
	typedef struct packed {
		logic load;
		logic cmp;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== design/aciq_in_if.sv =====
interface aciq_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic [aciq_pkg::KEY_W-1:0]    request_key;
	logic [aciq_pkg::COUNT_W-1:0]  unit_count;

	modport source (output valid, output operation, output request_key, output unit_count,
		input ready);
	modport sink (input valid, input operation, input request_key, input unit_count,
		output ready);
endinterface

// ===== design/aciq_out_if.sv =====
interface aciq_out_if #(
	parameter int WAIT_W = 5
);
	logic                          valid;
	logic                          ready;
	logic [2:0]                    event_kind;
	logic [aciq_pkg::KEY_W-1:0]    event_key;
	logic [aciq_pkg::COUNT_W-1:0]  event_count;
	logic [aciq_pkg::FREE_W-1:0]   free_now;
	logic [WAIT_W-1:0]             waiting_now;
	logic                          last_of_run;

	modport source (output valid, output event_kind, output event_key, output event_count,
		output free_now, output waiting_now, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input event_key, input event_count,
		input free_now, input waiting_now, input last_of_run, output ready);
endinterface

// ===== design/in_order_credit_admission_queue.sv =====
// Arrive, cancel miss and cancel of a non-head entry: the result is registered into the
// output register from the execute state. Release and head cancel: the execute state, then a
// drain state that gives one result a cycle from the head cell while the output is not
// stalled (k grants plus status); the next item can be taken in the cycle after the last.
// A new request is taken only in idle, once the previous one has given its last result.
// Reset: pool holds 10 units, queue empty, output idle; cell contents are not cleared.
// A configuration write reloads the pool (0 loads 10) and empties the queue.
module in_order_credit_admission_queue #(
	parameter int QUEUE_DEPTH = aciq_pkg::QUEUE_DEPTH_DEF,
	parameter int KEY_BITS    = aciq_pkg::KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [aciq_pkg::FREE_W-1:0]  cfg_wdata,
	aciq_in_if.sink                      req,
	aciq_out_if.source                   evt
);

	localparam int KW     = (KEY_BITS < aciq_pkg::KEY_W) ? KEY_BITS : aciq_pkg::KEY_W;
	localparam int WAIT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CW     = aciq_pkg::COUNT_W;
	localparam int FW     = aciq_pkg::FREE_W;

	aciq_pkg::state_t      state_q, state_d;
	aciq_pkg::op_t         op_q;
	aciq_pkg::event_kind_t fin_kind_q, fin_kind_d;
	logic [KW-1:0]         key_q;
	logic [CW-1:0]         count_q, fin_count_q, fin_count_d;
	logic [FW-1:0]         free_q, free_d;
	logic [WAIT_W-1:0]     occ_q, occ_d;

	logic                  out_valid_q;
	aciq_pkg::event_kind_t out_kind_q, e_kind;
	logic [aciq_pkg::KEY_W-1:0] out_key_q, e_key;
	logic [CW-1:0]         out_count_q, e_count;
	logic [FW-1:0]         out_free_q;
	logic [WAIT_W-1:0]     out_wait_q;
	logic                  out_last_q, e_last;
	logic                  emit, out_free, accept;

	aciq_pkg::cell_ctrl_t  ctrl;
	logic                  kill0;
	logic [QUEUE_DEPTH:0]  kill;
	logic [QUEUE_DEPTH-1:0] first;
	logic [KW-1:0]         cell_key  [QUEUE_DEPTH+1];
	logic [CW-1:0]         cell_size [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH-1:0] pick_col [CW];
	logic [CW-1:0]         picked;

	logic                  found, head_hit, head_fits, grant_now, room;
	logic [FW:0]           sum;
	logic [aciq_pkg::KEY_W-1:0] key_ext, head_key_ext;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || evt.ready;
	assign req.ready = (state_q == aciq_pkg::ST_IDLE);

	// ---------------- cell chain ----------------
	assign kill[0] = kill0;
	assign cell_key[QUEUE_DEPTH]  = '0;
	assign cell_size[QUEUE_DEPTH] = '0;

	for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
		logic [CW-1:0] pick_j;
		aciq_cell #(.KW(KW)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (WAIT_W'(j) < occ_q),
			.load_here  (WAIT_W'(j) == occ_q),
			.new_key    (key_q),
			.new_size   (count_q),
			.right_key  (cell_key[j+1]),
			.right_size (cell_size[j+1]),
			.kill_in    (kill[j]),
			.kill_out   (kill[j+1]),
			.first_hit  (first[j]),
			.key        (cell_key[j]),
			.size       (cell_size[j]),
			.pick_size  (pick_j)
		);
		for (genvar b = 0; b < CW; b++) begin : g_bit
			assign pick_col[b][j] = pick_j[b];
		end
	end

	for (genvar b = 0; b < CW; b++) begin : g_pick
		assign picked[b] = |pick_col[b];
	end

	assign found     = kill[QUEUE_DEPTH];
	assign head_hit  = first[0];
	assign head_fits = (occ_q != '0) && (free_q >= cell_size[0]);
	assign grant_now = (occ_q == '0) && (free_q >= count_q);
	assign room      = (occ_q < WAIT_W'(QUEUE_DEPTH));
	assign sum       = {1'b0, free_q} + {1'b0, count_q};

	always_comb begin
		key_ext = '0;
		key_ext[KW-1:0] = key_q;
		head_key_ext = '0;
		head_key_ext[KW-1:0] = cell_key[0];
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			aciq_pkg::ST_IDLE: begin
				if (accept) state_d = aciq_pkg::ST_EXEC;
			end
			aciq_pkg::ST_EXEC: begin
				if (out_free) begin
					case (op_q)
						aciq_pkg::OP_RELEASE: state_d = aciq_pkg::ST_DRAIN;
						aciq_pkg::OP_CANCEL:  state_d = (found && head_hit) ?
							aciq_pkg::ST_DRAIN : aciq_pkg::ST_IDLE;
						default:              state_d = aciq_pkg::ST_IDLE;
					endcase
				end
			end
			aciq_pkg::ST_DRAIN: begin
				if (out_free && !head_fits) state_d = aciq_pkg::ST_IDLE;
			end
			default: state_d = aciq_pkg::ST_IDLE;
		endcase
	end

	// ---------------- datapath control ----------------
	always_comb begin
		ctrl        = '0;
		kill0       = 1'b0;
		emit        = 1'b0;
		e_kind      = aciq_pkg::EV_GRANTED;
		e_key       = '0;
		e_count     = '0;
		e_last      = 1'b0;
		free_d      = free_q;
		occ_d       = occ_q;
		fin_kind_d  = fin_kind_q;
		fin_count_d = fin_count_q;
		case (state_q)
			aciq_pkg::ST_EXEC: begin
				if (out_free) begin
					case (op_q)
						aciq_pkg::OP_ARRIVE: begin
							emit    = 1'b1;
							e_last  = 1'b1;
							e_key   = key_ext;
							e_count = count_q;
							if (grant_now) begin
								e_kind = aciq_pkg::EV_GRANTED;
								free_d = free_q - count_q;
							end else if (room) begin
								e_kind    = aciq_pkg::EV_QUEUED;
								ctrl.load = 1'b1;
								occ_d     = occ_q + 1'b1;
							end else begin
								e_kind = aciq_pkg::EV_REJECTED;
							end
						end
						aciq_pkg::OP_RELEASE: begin
							free_d      = sum[FW] ? aciq_pkg::MAX_UNITS : sum[FW-1:0];
							fin_kind_d  = aciq_pkg::EV_RELEASE_DONE;
							fin_count_d = count_q;
						end
						aciq_pkg::OP_CANCEL: begin
							ctrl.cmp = 1'b1;
							if (found) begin
								ctrl.shift  = 1'b1;
								occ_d       = occ_q - 1'b1;
								fin_kind_d  = aciq_pkg::EV_CANCEL_DONE;
								fin_count_d = picked;
								if (!head_hit) begin
									emit    = 1'b1;
									e_last  = 1'b1;
									e_kind  = aciq_pkg::EV_CANCEL_DONE;
									e_key   = key_ext;
									e_count = picked;
								end
							end else begin
								emit   = 1'b1;
								e_last = 1'b1;
								e_kind = aciq_pkg::EV_CANCEL_MISS;
								e_key  = key_ext;
							end
						end
						default: ;
					endcase
				end
			end
			aciq_pkg::ST_DRAIN: begin
				if (out_free) begin
					emit = 1'b1;
					if (head_fits) begin
						// grant head: every cell advances one place
						ctrl.shift = 1'b1;
						kill0      = 1'b1;
						e_kind     = aciq_pkg::EV_GRANTED;
						e_key      = head_key_ext;
						e_count    = cell_size[0];
						free_d     = free_q - cell_size[0];
						occ_d      = occ_q - 1'b1;
					end else begin
						e_kind  = fin_kind_q;
						e_key   = (fin_kind_q == aciq_pkg::EV_RELEASE_DONE) ? '0 : key_ext;
						e_count = fin_count_q;
						e_last  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aciq_pkg::ST_IDLE;
			free_q      <= aciq_pkg::DEFAULT_UNITS;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				free_q <= (cfg_wdata == '0) ? aciq_pkg::DEFAULT_UNITS : cfg_wdata;
				occ_q  <= '0;
			end else begin
				free_q <= free_d;
				occ_q  <= occ_d;
			end
			if (emit)           out_valid_q <= 1'b1;
			else if (evt.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= aciq_pkg::op_t'(req.operation);
			key_q   <= req.request_key[KW-1:0];
			count_q <= req.unit_count;
		end
		fin_kind_q  <= fin_kind_d;
		fin_count_q <= fin_count_d;
		if (emit) begin
			out_kind_q  <= e_kind;
			out_key_q   <= e_key;
			out_count_q <= e_count;
			out_free_q  <= free_d;
			out_wait_q  <= occ_d;
			out_last_q  <= e_last;
		end
	end

	assign evt.valid       = out_valid_q;
	assign evt.event_kind  = out_kind_q;
	assign evt.event_key   = out_key_q;
	assign evt.event_count = out_count_q;
	assign evt.free_now    = out_free_q;
	assign evt.waiting_now = out_wait_q;
	assign evt.last_of_run = out_last_q;

	// ---------------- assertions ----------------
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= WAIT_W'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first))
		else $error("more than one cell claims the cancel");

	a_drain_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aciq_pkg::ST_DRAIN && out_free && head_fits && !cfg_we)
		|=> occ_q == $past(occ_q) - 1'b1)
		else $error("head grant did not retire a queue entry");

	a_drain_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aciq_pkg::ST_DRAIN && state_d == aciq_pkg::ST_IDLE)
		|=> out_valid_q && out_last_q)
		else $error("drain finished without a final status result");

endmodule

// ===== design/aciq_cell.sv =====
// One queue slot. Removal propagates rightward through kill_in/kill_out:
// a cell at or after the removed slot takes its right neighbor's entry.
module aciq_cell #(
	parameter int KW = aciq_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  aciq_pkg::cell_ctrl_t          ctrl,
	input  logic                          occupied,
	input  logic                          load_here,
	input  logic [KW-1:0]                 new_key,
	input  logic [aciq_pkg::COUNT_W-1:0]  new_size,
	input  logic [KW-1:0]                 right_key,
	input  logic [aciq_pkg::COUNT_W-1:0]  right_size,
	input  logic                          kill_in,
	output logic                          kill_out,
	output logic                          first_hit,
	output logic [KW-1:0]                 key,
	output logic [aciq_pkg::COUNT_W-1:0]  size,
	output logic [aciq_pkg::COUNT_W-1:0]  pick_size
);

	logic [KW-1:0]                key_q;
	logic [aciq_pkg::COUNT_W-1:0] size_q;
	logic                         hit;

	assign hit       = ctrl.cmp && occupied && (key_q == new_key);
	assign kill_out  = kill_in || hit;
	assign first_hit = hit && !kill_in;
	assign pick_size = first_hit ? size_q : '0;
	assign key       = key_q;
	assign size      = size_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift && kill_out) begin
			key_q  <= right_key;
			size_q <= right_size;
		end else if (ctrl.load && load_here) begin
			key_q  <= new_key;
			size_q <= new_size;
		end
	end

endmodule
